/* rtl/amlp_pkg.sv */
// Shared codes, character constants and helpers for the ASCII meter line parser.
// No dependencies.
`default_nettype none

package amlp_pkg;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_IMPLAUS  = 3'd1;
	localparam logic [2:0] ST_NO_NUM   = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_MANT_OVF = 3'd4;

	// Overload mark kinds
	localparam logic [1:0] OV_NONE   = 2'd0;
	localparam logic [1:0] OV_PLAIN  = 2'd1;
	localparam logic [1:0] OV_DOTTED = 2'd2;

	// Unit prefix codes
	localparam logic [2:0] PFX_NONE  = 3'd0;
	localparam logic [2:0] PFX_NANO  = 3'd1;
	localparam logic [2:0] PFX_MICRO = 3'd2;
	localparam logic [2:0] PFX_MILLI = 3'd3;
	localparam logic [2:0] PFX_KILO  = 3'd4;
	localparam logic [2:0] PFX_MEGA  = 3'd5;

	// Quantity (unit) codes
	localparam logic [2:0] QTY_NONE = 3'd0;
	localparam logic [2:0] QTY_VOLT = 3'd1;
	localparam logic [2:0] QTY_AMP  = 3'd2;
	localparam logic [2:0] QTY_OHM  = 3'd3;
	localparam logic [2:0] QTY_FARAD = 3'd4;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_K  = 8'h4B;
	localparam logic [7:0] CH_UC_L  = 8'h4C;
	localparam logic [7:0] CH_UC_M  = 8'h4D;
	localparam logic [7:0] CH_UC_R  = 8'h52;
	localparam logic [7:0] CH_UC_V  = 8'h56;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_M  = 8'h6D;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
	endfunction

	// Decimal-place adjustment for a prefix, in base units
	function automatic logic signed [7:0] prefix_adj(input logic [2:0] code);
		logic signed [7:0] adj;
		unique case (code)
			PFX_NANO:  adj = 8'sd9;
			PFX_MICRO: adj = 8'sd6;
			PFX_MILLI: adj = 8'sd3;
			PFX_KILO:  adj = -8'sd3;
			PFX_MEGA:  adj = -8'sd6;
			default:   adj = 8'sd0;
		endcase
		return adj;
	endfunction

endpackage

`default_nettype wire

/* rtl/ascii_meter_line_parser.sv */
// ASCII meter line parser: per-byte line state and the registered reading.
// Depends on amlp_pkg.
`default_nettype none

// Takes one byte per clock on the input channel and keeps the running parse
// state of the current line in registers; each byte updates that state in the
// cycle it is accepted. A newline (0x0A) loads one reading into the output
// register, which is shown in the cycle after the newline is taken. The input is
// ready whenever the output register is empty or being emptied in the same
// cycle, so the sustained rate is one byte per cycle; the only stall is a
// reading that is held waiting on out_ready. Bytes other than newline produce
// no reading. Lines longer than MAX_LINE bytes are discarded up to the newline
// and reported as too long. MANTISSA_DIGITS sets the largest accepted magnitude.
// There is no clearing pass after reset.
module ascii_meter_line_parser
	import amlp_pkg::*;
#(
	parameter int MAX_LINE        = 16,
	parameter int MANTISSA_DIGITS = 9
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         byte_req,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic                    overload,
	output logic signed [30:0]      mantissa,
	output logic signed [5:0]       decimal_places,
	output logic [2:0]              quantity,
	output logic [4:0]              line_length
);

	function automatic longint unsigned pow10_minus1(input int digits);
		longint unsigned v;
		v = 64'd1;
		for (int i = 0; i < digits; i++) begin
			v = v * 64'd10;
		end
		return v - 64'd1;
	endfunction

	localparam longint unsigned MANT_LIMIT = pow10_minus1(MANTISSA_DIGITS);
	localparam int ACC_W = $clog2(MANT_LIMIT + 64'd1);
	localparam int NXT_W = ACC_W + 4;
	localparam int CNT_W = $clog2(MAX_LINE + 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LINE);
	localparam logic [4:0]       LONG_LEN = 5'((MAX_LINE + 1) % 32);
	localparam logic [NXT_W-1:0] NXT_LIMIT = NXT_W'(MANT_LIMIT);

	// Parse phase codes
	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_TSKIP  = 3'd3;
	localparam logic [2:0] PH_TUNIT  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// Line state
	logic [CNT_W-1:0] count_q,    count_d;
	logic [2:0]       phase_q,    phase_d;
	logic             neg_q,      neg_d;
	logic [ACC_W-1:0] acc_q,      acc_d;
	logic             too_big_q,  too_big_d;
	logic [5:0]       frac_q,     frac_d;
	logic             dot_q,      dot_d;
	logic             any_dig_q,  any_dig_d;
	logic             any_let_q,  any_let_d;
	logic [15:0]      last_q,     last_d;
	logic [1:0]       ovk_q,      ovk_d;
	logic [2:0]       prefix_q,   prefix_d;
	logic [2:0]       unit_q,     unit_d;
	logic             discard_q,  discard_d;
	logic             ended_q,    ended_d;
	logic             found_q,    found_d;

	// Output register
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic             overload_q;
	logic [30:0]      mantissa_q;
	logic [5:0]       dp_q;
	logic [2:0]       quantity_q;
	logic [4:0]       len_q;

	logic in_acc;
	logic is_nl;
	logic load_res;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign is_nl    = (byte_req == CH_NL);
	assign load_res = in_acc && is_nl;

	// Mantissa accumulate: acc*10 + digit as shift-add
	logic [NXT_W-1:0] acc_ext;
	logic [NXT_W-1:0] acc_next;
	assign acc_ext  = NXT_W'(acc_q);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + NXT_W'(byte_req - CH_ZERO);

	// Reading formed from the current line state
	logic signed [7:0]  adj;
	logic signed [7:0]  dp_full;
	logic [30:0]        mag31;
	logic [2:0]         res_status;
	logic               res_ovl;
	logic [30:0]        res_mant;
	logic [5:0]         res_dp;
	logic [2:0]         res_qty;
	logic [4:0]         res_len;

	assign adj     = prefix_adj(prefix_q);
	assign dp_full = $signed({2'b00, frac_q}) + adj;
	assign mag31   = 31'(acc_q);

	always_comb begin
		res_status = ST_OK;
		res_ovl    = 1'b0;
		res_mant   = '0;
		res_dp     = '0;
		res_qty    = QTY_NONE;
		res_len    = 5'({1'b0, count_q} + (CNT_W+1)'(1));
		if (discard_q) begin
			res_status = ST_TOO_LONG;
			res_len    = LONG_LEN;
		end else if (!(any_dig_q && any_let_q)) begin
			res_status = ST_IMPLAUS;
		end else if (ovk_q != OV_NONE) begin
			res_ovl = 1'b1;
			res_dp  = adj[5:0];
			res_qty = unit_q;
		end else if (!found_q) begin
			res_status = ST_NO_NUM;
		end else begin
			res_dp  = dp_full[5:0];
			res_qty = unit_q;
			if (too_big_q || dp_full < -8'sd32 || dp_full > 8'sd31) begin
				res_status = ST_MANT_OVF;
			end else begin
				res_mant = neg_q ? (31'd0 - mag31) : mag31;
			end
		end
	end

	// Next line state for one accepted byte
	logic       tail_go;
	logic [2:0] tail_ph;
	logic       mark;
	logic [2:0] pfx_hit;
	logic [7:0] p1, p2;

	assign p1 = last_q[7:0];
	assign p2 = last_q[15:8];

	always_comb begin
		count_d   = count_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		acc_d     = acc_q;
		too_big_d = too_big_q;
		frac_d    = frac_q;
		dot_d     = dot_q;
		any_dig_d = any_dig_q;
		any_let_d = any_let_q;
		last_d    = last_q;
		ovk_d     = ovk_q;
		prefix_d  = prefix_q;
		unit_d    = unit_q;
		discard_d = discard_q;
		ended_d   = ended_q;
		found_d   = found_q;
		tail_go   = 1'b0;
		tail_ph   = phase_q;
		mark      = 1'b0;
		pfx_hit   = PFX_NONE;

		if (in_acc) begin
			if (is_nl) begin
				// End of line: back to the reset state
				count_d   = '0;
				phase_d   = PH_LEAD;
				neg_d     = 1'b0;
				acc_d     = '0;
				too_big_d = 1'b0;
				frac_d    = '0;
				dot_d     = 1'b0;
				any_dig_d = 1'b0;
				any_let_d = 1'b0;
				last_d    = '0;
				ovk_d     = OV_NONE;
				prefix_d  = PFX_NONE;
				unit_d    = QTY_NONE;
				discard_d = 1'b0;
				ended_d   = 1'b0;
				found_d   = 1'b0;
			end else if (!discard_q) begin
				if (count_q >= CNT_MAX) begin
					discard_d = 1'b1;
				end else begin
					count_d = count_q + CNT_W'(1);
					if (is_digit(byte_req)) any_dig_d = 1'b1;
					if (is_alpha(byte_req)) any_let_d = 1'b1;
					if (!ended_q) begin
						if (byte_req == CH_NUL) begin
							ended_d = 1'b1;
							phase_d = PH_DONE;
						end else begin
							last_d = {last_q[7:0], byte_req};
							// Overload mark: dotted form outranks plain
							if (byte_req == CH_UC_L) begin
								if (p1 == CH_DOT && p2 == CH_ZERO && ovk_q != OV_DOTTED) begin
									ovk_d = OV_DOTTED;
									mark  = 1'b1;
								end else if (p1 == CH_ZERO && ovk_q == OV_NONE) begin
									ovk_d = OV_PLAIN;
									mark  = 1'b1;
								end
							end
							if (mark) begin
								prefix_d = PFX_NONE;
								unit_d   = QTY_NONE;
								phase_d  = PH_TSKIP;
							end else if (phase_q <= PH_DIGITS) begin
								// Number section
								if (phase_q == PH_LEAD && is_space(byte_req)) begin
									phase_d = PH_LEAD;
								end else if (phase_q == PH_LEAD && byte_req == CH_MINUS) begin
									neg_d   = 1'b1;
									phase_d = PH_SIGNED;
								end else if (phase_q == PH_LEAD && byte_req == CH_PLUS) begin
									phase_d = PH_SIGNED;
								end else if (is_digit(byte_req)) begin
									if (!too_big_q) begin
										if (acc_next > NXT_LIMIT) too_big_d = 1'b1;
										else acc_d = ACC_W'(acc_next);
									end
									if (dot_q && frac_q < 6'd63) frac_d = frac_q + 6'd1;
									found_d = 1'b1;
									phase_d = PH_DIGITS;
								end else if (byte_req == CH_DOT && !dot_q) begin
									dot_d = 1'b1;
									if (phase_q == PH_LEAD) phase_d = PH_SIGNED;
								end else if (found_q) begin
									tail_go = 1'b1;
									tail_ph = PH_TSKIP;
								end else begin
									phase_d = PH_DONE;
								end
							end else begin
								tail_go = 1'b1;
							end
						end
					end
				end
			end
		end

		// Tail: optional prefix then optional unit letter
		unique case (byte_req)
			CH_LC_N: pfx_hit = PFX_NANO;
			CH_LC_U: pfx_hit = PFX_MICRO;
			CH_LC_M: pfx_hit = PFX_MILLI;
			CH_UC_K: pfx_hit = PFX_KILO;
			CH_UC_M: pfx_hit = PFX_MEGA;
			default: pfx_hit = PFX_NONE;
		endcase

		if (tail_go) begin
			phase_d = tail_ph;
			if (tail_ph == PH_TSKIP) begin
				if (!(is_space(byte_req) || is_digit(byte_req) || byte_req == CH_DOT)) begin
					if (pfx_hit != PFX_NONE) prefix_d = pfx_hit;
					if (pfx_hit != PFX_NONE || prefix_q != PFX_NONE) begin
						phase_d = PH_TUNIT;
					end else begin
						phase_d = PH_DONE;
						unique case (byte_req)
							CH_UC_V: unit_d = QTY_VOLT;
							CH_UC_A: unit_d = QTY_AMP;
							CH_UC_R: unit_d = QTY_OHM;
							CH_UC_F: unit_d = QTY_FARAD;
							default: unit_d = unit_q;
						endcase
					end
				end
			end else if (tail_ph == PH_TUNIT) begin
				phase_d = PH_DONE;
				unique case (byte_req)
					CH_UC_V: unit_d = QTY_VOLT;
					CH_UC_A: unit_d = QTY_AMP;
					CH_UC_R: unit_d = QTY_OHM;
					CH_UC_F: unit_d = QTY_FARAD;
					default: unit_d = unit_q;
				endcase
			end
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			phase_q   <= PH_LEAD;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			too_big_q <= 1'b0;
			frac_q    <= '0;
			dot_q     <= 1'b0;
			any_dig_q <= 1'b0;
			any_let_q <= 1'b0;
			last_q    <= '0;
			ovk_q     <= OV_NONE;
			prefix_q  <= PFX_NONE;
			unit_q    <= QTY_NONE;
			discard_q <= 1'b0;
			ended_q   <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			count_q   <= count_d;
			phase_q   <= phase_d;
			neg_q     <= neg_d;
			acc_q     <= acc_d;
			too_big_q <= too_big_d;
			frac_q    <= frac_d;
			dot_q     <= dot_d;
			any_dig_q <= any_dig_d;
			any_let_q <= any_let_d;
			last_q    <= last_d;
			ovk_q     <= ovk_d;
			prefix_q  <= prefix_d;
			unit_q    <= unit_d;
			discard_q <= discard_d;
			ended_q   <= ended_d;
			found_q   <= found_d;
		end
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (load_res) begin
			status_q   <= res_status;
			overload_q <= res_ovl;
			mantissa_q <= res_mant;
			dp_q       <= res_dp;
			quantity_q <= res_qty;
			len_q      <= res_len;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign overload       = overload_q;
	assign mantissa       = $signed(mantissa_q);
	assign decimal_places = $signed(dp_q);
	assign quantity       = quantity_q;
	assign line_length    = len_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("byte count past line limit");

	a_nl_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> out_valid_q)
		else $error("newline did not produce a word");

	a_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_TOO_LONG) |-> (len_q == LONG_LEN && !overload_q))
		else $error("overlong line word malformed");

	a_ovl_mant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overload_q) |-> (mantissa_q == '0 && status_q == ST_OK))
		else $error("overload word carries a mantissa");
`endif

endmodule

`default_nettype wire

/* sim/tb_ascii_meter_line_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII meter line parser: directed lines, then random
// lines with idle gaps on both channels, each reading checked against a line predictor.
// Depends on amlp_pkg and ascii_meter_line_parser.

module tb_ascii_meter_line_parser;
	import amlp_pkg::*;

	localparam int MAX_LINE    = 16;
	localparam int MANT_DIGITS = 9;
	localparam logic [63:0] MANT_LIMIT = 64'd10 ** MANT_DIGITS - 64'd1;
	localparam int DRAIN_MARK  = -1;
	localparam int RAND_BYTES  = 1800;
	localparam int TAIL_CYCLES = 16;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LC_X = 8'h78;
	localparam logic [7:0] CH_UC_X = 8'h58;

	typedef enum logic [2:0] {
		SCAN_LEAD, SCAN_SIGNED, SCAN_DIGITS, SCAN_TAIL_SKIP, SCAN_TAIL_UNIT, SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               overload;
		logic signed [30:0] mantissa;
		logic signed [5:0]  decimal_places;
		logic [2:0]         quantity;
		logic [4:0]         line_length;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         byte_req = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic               overload;
	logic signed [30:0] mantissa;
	logic signed [5:0]  decimal_places;
	logic [2:0]         quantity;
	logic [4:0]         line_length;

	ascii_meter_line_parser #(
		.MAX_LINE(MAX_LINE),
		.MANTISSA_DIGITS(MANT_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_req(byte_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.overload(overload),
		.mantissa(mantissa),
		.decimal_places(decimal_places),
		.quantity(quantity),
		.line_length(line_length)
	);

	always #4 clk = ~clk;

	// pending bytes (DRAIN_MARK = wait for all readings) and readings still owed
	int       pend_q[$];
	reading_t reading_q[$];
	int       queued_bytes = 0;
	int       bytes_taken = 0;
	int       readings_seen = 0;
	int       overloads_seen = 0;
	int       status_seen[8];
	int       mismatches = 0;

	// line predictor state
	int          ln_count;
	scan_phase_t ln_phase;
	logic        ln_neg, ln_big, ln_dot, ln_digit, ln_letter, ln_found;
	logic        ln_discard, ln_ended;
	logic [63:0] ln_acc;
	int          ln_frac;
	logic [15:0] ln_hist;
	logic [1:0]  ln_ovl;
	logic [2:0]  ln_pfx, ln_unit;

	function automatic logic char_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic logic char_letter(input logic [7:0] b);
		return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
	endfunction

	function automatic logic char_blank(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= 8'h0D);
	endfunction

	function automatic int decimal_shift(input logic [2:0] code);
		case (code)
			PFX_NANO:  return 9;
			PFX_MICRO: return 6;
			PFX_MILLI: return 3;
			PFX_KILO:  return -3;
			PFX_MEGA:  return -6;
			default:   return 0;
		endcase
	endfunction

	task automatic ln_clear();
		ln_count = 0;
		ln_phase = SCAN_LEAD;
		ln_neg = 1'b0;
		ln_acc = '0;
		ln_big = 1'b0;
		ln_frac = 0;
		ln_dot = 1'b0;
		ln_digit = 1'b0;
		ln_letter = 1'b0;
		ln_hist = '0;
		ln_ovl = OV_NONE;
		ln_pfx = PFX_NONE;
		ln_unit = QTY_NONE;
		ln_discard = 1'b0;
		ln_ended = 1'b0;
		ln_found = 1'b0;
	endtask

	task automatic take_unit(input logic [7:0] b);
		case (b)
			CH_UC_V: ln_unit = QTY_VOLT;
			CH_UC_A: ln_unit = QTY_AMP;
			CH_UC_R: ln_unit = QTY_OHM;
			CH_UC_F: ln_unit = QTY_FARAD;
			default: ;
		endcase
		ln_phase = SCAN_DONE;
	endtask

	// after the number: skip digits/dots/blanks, then optional prefix, then unit
	task automatic tail_char(input logic [7:0] b);
		if (ln_phase == SCAN_TAIL_SKIP) begin
			if (!(char_blank(b) || char_digit(b) || b == CH_DOT)) begin
				case (b)
					CH_LC_N: ln_pfx = PFX_NANO;
					CH_LC_U: ln_pfx = PFX_MICRO;
					CH_LC_M: ln_pfx = PFX_MILLI;
					CH_UC_K: ln_pfx = PFX_KILO;
					CH_UC_M: ln_pfx = PFX_MEGA;
					default: ;
				endcase
				if (ln_pfx != PFX_NONE)
					ln_phase = SCAN_TAIL_UNIT;
				else
					take_unit(b);
			end
		end else if (ln_phase == SCAN_TAIL_UNIT) begin
			take_unit(b);
		end
	endtask

	task automatic number_char(input logic [7:0] b);
		logic [63:0] nxt;
		logic        used;
		used = 1'b0;
		if (ln_phase == SCAN_LEAD) begin
			if (char_blank(b)) begin
				used = 1'b1;
			end else if (b == CH_MINUS) begin
				ln_neg = 1'b1;
				ln_phase = SCAN_SIGNED;
				used = 1'b1;
			end else if (b == CH_PLUS) begin
				ln_phase = SCAN_SIGNED;
				used = 1'b1;
			end
		end
		if (!used) begin
			if (char_digit(b)) begin
				if (!ln_big) begin
					nxt = ln_acc * 64'd10 + 64'(b - CH_ZERO);
					if (nxt > MANT_LIMIT)
						ln_big = 1'b1;
					else
						ln_acc = nxt;
				end
				if (ln_dot && ln_frac < 63)
					ln_frac++;
				ln_found = 1'b1;
				ln_phase = SCAN_DIGITS;
			end else if (b == CH_DOT && !ln_dot) begin
				ln_dot = 1'b1;
				if (ln_phase == SCAN_LEAD)
					ln_phase = SCAN_SIGNED;
			end else if (ln_found) begin
				ln_phase = SCAN_TAIL_SKIP;
				tail_char(b);
			end else begin
				ln_phase = SCAN_DONE;
			end
		end
	endtask

	// advance the line predictor by one accepted word; a newline owes a reading
	task automatic parse_byte(input logic [7:0] b);
		reading_t    r;
		logic [7:0]  p1, p2;
		logic        mark;
		int          adj, dp;
		logic [63:0] m;
		if (b == CH_NL) begin
			r = '0;
			if (ln_discard) begin
				r.status = ST_TOO_LONG;
				r.line_length = 5'(MAX_LINE + 1);
			end else begin
				adj = decimal_shift(ln_pfx);
				r.line_length = 5'(ln_count + 1);
				if (!(ln_digit && ln_letter)) begin
					r.status = ST_IMPLAUS;
				end else if (ln_ovl != OV_NONE) begin
					r.overload = 1'b1;
					r.decimal_places = 6'(adj);
					r.quantity = ln_unit;
				end else if (!ln_found) begin
					r.status = ST_NO_NUM;
				end else begin
					dp = ln_frac + adj;
					r.decimal_places = 6'(dp);
					r.quantity = ln_unit;
					if (ln_big || dp < -32 || dp > 31) begin
						r.status = ST_MANT_OVF;
					end else begin
						m = ln_neg ? (64'd0 - ln_acc) : ln_acc;
						r.mantissa = m[30:0];
					end
				end
			end
			reading_q.push_back(r);
			ln_clear();
		end else if (!ln_discard) begin
			if (ln_count >= MAX_LINE) begin
				ln_discard = 1'b1;
			end else begin
				ln_count++;
				if (char_digit(b))
					ln_digit = 1'b1;
				if (char_letter(b))
					ln_letter = 1'b1;
				if (!ln_ended) begin
					if (b == CH_NUL) begin
						// text ends here; length and plausibility still count
						ln_ended = 1'b1;
						ln_phase = SCAN_DONE;
					end else begin
						p1 = ln_hist[7:0];
						p2 = ln_hist[15:8];
						ln_hist = {ln_hist[7:0], b};
						mark = 1'b0;
						if (b == CH_UC_L) begin
							if (p1 == CH_DOT && p2 == CH_ZERO && ln_ovl != OV_DOTTED) begin
								ln_ovl = OV_DOTTED;
								mark = 1'b1;
							end else if (p1 == CH_ZERO && ln_ovl == OV_NONE) begin
								ln_ovl = OV_PLAIN;
								mark = 1'b1;
							end
						end
						if (mark) begin
							ln_pfx = PFX_NONE;
							ln_unit = QTY_NONE;
							ln_phase = SCAN_TAIL_SKIP;
						end else if (ln_phase <= SCAN_DIGITS) begin
							number_char(b);
						end else begin
							tail_char(b);
						end
					end
				end
			end
		end
	endtask

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(25, 60);
	endfunction

	// driver: one word per handshake, gaps between words, drain points on request
	int src_gap = 0;
	int src_quiet = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(byte_req);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (pend_q.size() != 0 && pend_q[0] == DRAIN_MARK) begin
					in_valid <= 1'b0;
					if (reading_q.size() == 0)
						void'(pend_q.pop_front());
				end else if (pend_q.size() != 0) begin
					in_valid <= 1'b1;
					byte_req <= 8'(pend_q.pop_front());
					if (src_quiet > 0) begin
						src_quiet--;
						src_gap = 0;
					end else begin
						src_gap = pick_gap();
						if ($urandom_range(0, 99) == 0)
							src_quiet = $urandom_range(40, 150);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, compare each reading with the oldest one owed
	int sink_gap = 0;
	int sink_quiet = 0;
	always @(posedge clk) begin
		reading_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, overload, mantissa, decimal_places, quantity, line_length};
				readings_seen++;
				status_seen[status]++;
				if (overload)
					overloads_seen++;
				if (reading_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reading with none owed: st=%0d len=%0d",
							$realtime, got.status, got.line_length);
				end else begin
					want = reading_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp st=%0d ov=%0d m=%0d dp=%0d q=%0d len=%0d",
								$realtime, want.status, want.overload, want.mantissa,
								want.decimal_places, want.quantity, want.line_length);
							$display("            got st=%0d ov=%0d m=%0d dp=%0d q=%0d len=%0d",
								got.status, got.overload, got.mantissa,
								got.decimal_places, got.quantity, got.line_length);
						end
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (sink_quiet > 0) begin
					sink_quiet--;
				end else begin
					sink_gap = pick_gap();
					if ($urandom_range(0, 99) == 0)
						sink_quiet = $urandom_range(40, 150);
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pend_q.push_back(int'(b));
		queued_bytes++;
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == CH_NL) ? 8'h0B : b;
	endfunction

	// optional sign, digits with at most one dot; sometimes long or all nines
	task automatic push_number();
		int   nd, dotpos, i;
		logic nines;
		case ($urandom_range(0, 3))
			0: push_byte(CH_MINUS);
			1: push_byte(CH_PLUS);
			default: ;
		endcase
		nd = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
		dotpos = ($urandom_range(0, 1) == 1) ? $urandom_range(0, nd) : -1;
		nines = ($urandom_range(0, 9) == 0);
		for (i = 0; i < nd; i++) begin
			if (i == dotpos)
				push_byte(CH_DOT);
			push_byte(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if (dotpos == nd)
			push_byte(CH_DOT);
	endtask

	// optional prefix and unit, now and then a stray letter
	task automatic push_suffix();
		case ($urandom_range(0, 7))
			0: push_byte(CH_LC_N);
			1: push_byte(CH_LC_U);
			2: push_byte(CH_LC_M);
			3: push_byte(CH_UC_K);
			4: push_byte(CH_UC_M);
			5: if ($urandom_range(0, 3) == 0) push_byte(CH_LC_X);
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: push_byte(CH_UC_V);
			1: push_byte(CH_UC_A);
			2: push_byte(CH_UC_R);
			3: push_byte(CH_UC_F);
			4: push_byte(($urandom_range(0, 1) == 1) ? CH_UC_X : CH_UC_V);
			default: ;
		endcase
	endtask

	initial begin
		int kind, n, i;
		ln_clear();
		foreach (status_seen[k])
			status_seen[k] = 0;

		// directed lines: units, prefixes, signs, limits, marks and rejects
		push_text("1.234V\n");
		push_text("-0.5mA\n");
		push_text("+12nF\n");
		push_text("  .75uR\n");
		push_text("999999999KV\n");
		push_text("-1000000000MA\n");
		push_text("0.LV\n");
		push_text("-0LmR\n");
		push_text("0L 0.LuF\n");
		push_text("abc\n");
		push_text("123\n");
		push_text("V12\n");
		push_text("\n");
		push_text("1e3V\n");
		push_text("123456789012345V\n");
		push_text("12345678901234567V\n");
		push_byte(CH_TAB);
		push_text("-7.A\n");
		push_text("7");
		push_byte(CH_NUL);
		push_text("V\n");
		push_byte(8'hFF);
		push_text("3V\n");
		push_text("5 xV\n");
		push_text("2mX\n");
		pend_q.push_back(DRAIN_MARK);

		// random lines, mostly well formed
		while (queued_bytes < RAND_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				repeat ($urandom_range(0, 2))
					push_byte(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE);
				push_number();
				if ($urandom_range(0, 3) == 0)
					push_byte(CH_SPACE);
				push_suffix();
			end else if (kind < 65) begin
				if ($urandom_range(0, 2) == 0)
					push_byte(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_SPACE);
				push_text(($urandom_range(0, 1) == 1) ? "0.L" : "0L");
				push_suffix();
			end else if (kind < 80) begin
				repeat ($urandom_range(0, 18))
					push_byte(noise_byte());
			end else if (kind < 90) begin
				// around the length limit
				n = $urandom_range(14, 22);
				for (i = 0; i < n; i++)
					push_byte((i % 4 == 3) ? CH_UC_V : CH_ZERO + 8'($urandom_range(0, 9)));
			end else begin
				push_number();
				push_byte(noise_byte());
				push_suffix();
			end
			push_byte(CH_NL);
			if ($urandom_range(0, 59) == 0)
				pend_q.push_back(DRAIN_MARK);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || in_valid)
			@(posedge clk);
		while (reading_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (reading_q.size() != 0)
			mismatches += reading_q.size();

		$display("Sent %0d bytes, checked %0d readings (%0d overload).",
			bytes_taken, readings_seen, overloads_seen);
		$display("By status: ok %0d, implausible %0d, no number %0d, too long %0d, overflow %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
